[rtl/msd_pkg.sv]
// Shared widths, step counts and pipeline stage records for the
// mean / standard deviation block. No dependencies.
package msd_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned DEV_W      = 32;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned WIDE_W     = 128;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned ROOT_STEPS = 32;
    localparam int unsigned MNUM_W     = 69;
    localparam int unsigned MDEN_W     = 65;
    localparam int unsigned VNUM_W     = 136;
    localparam int unsigned VDEN_W     = 129;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              m_ovf;
        logic [MDEN_W-1:0] m_rem;
        logic [MDEN_W-1:0] m_den;
        logic [DATA_W-1:0] m_lo;
        logic [DATA_W-1:0] m_quo;
        logic              v_neg;
        logic              v_ovf;
        logic [VDEN_W-1:0] v_rem;
        logic [VDEN_W-1:0] v_den;
        logic [DATA_W-1:0] v_lo;
        logic [DATA_W-1:0] v_quo;
    } div_stage_t;

    typedef struct packed {
        logic              valid;
        logic              dev_zero;
        logic              dev_sat;
        logic [DATA_W-1:0] mean;
        logic [DATA_W-1:0] rad;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] one;
    } root_stage_t;

endpackage

[rtl/msd_in_if.sv]
// Request channel carrying one statistics snapshot.
// Depends on msd_pkg for field widths.
interface msd_in_if;
    logic                       valid;
    logic                       ready;
    logic [msd_pkg::DATA_W-1:0] sample_count;
    logic [msd_pkg::DATA_W-1:0] value_sum;
    logic [msd_pkg::DATA_W-1:0] square_sum;

    modport source (output valid, output sample_count, output value_sum,
                    output square_sum, input ready);
    modport sink (input valid, input sample_count, input value_sum,
                  input square_sum, output ready);
endinterface

[rtl/msd_out_if.sv]
// Result channel carrying mean and deviation in tenths.
// Depends on msd_pkg for field widths.
interface msd_out_if;
    logic                       valid;
    logic                       ready;
    logic [msd_pkg::DATA_W-1:0] mean_tenths;
    logic [msd_pkg::DEV_W-1:0]  deviation_tenths;

    modport source (output valid, output mean_tenths, output deviation_tenths,
                    input ready);
    modport sink (input valid, input mean_tenths, input deviation_tenths,
                  output ready);
endinterface

[rtl/msd_front.sv]
// Front stages: split products, moment sums, variance numerator and
// divider setup. Depends on msd_pkg.
module msd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       take,
    input  logic [msd_pkg::DATA_W-1:0] sample_count,
    input  logic [msd_pkg::DATA_W-1:0] value_sum,
    input  logic [msd_pkg::DATA_W-1:0] square_sum,
    output msd_pkg::div_stage_t        dout
);
    localparam int unsigned H = msd_pkg::HALF_W;
    localparam int unsigned D = msd_pkg::DATA_W;
    localparam int unsigned W = msd_pkg::WIDE_W;

    logic                          a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                          a_zero_reg, b_zero_reg, c_zero_reg, d_zero_reg;
    logic [D-1:0]                  nq_ll_reg, nq_lh_reg, nq_hl_reg, nq_hh_reg;
    logic [D-1:0]                  ss_ll_reg, ss_lh_reg, ss_hh_reg;
    logic [D-1:0]                  nn_ll_reg, nn_lh_reg, nn_hh_reg;
    logic [msd_pkg::MNUM_W-1:0]    a_mnum_reg, b_mnum_reg, c_mnum_reg, d_mnum_reg;
    logic [msd_pkg::MDEN_W-1:0]    a_mden_reg, b_mden_reg, c_mden_reg, d_mden_reg;
    logic                          b_movf_reg, c_movf_reg, d_movf_reg;
    logic [W-1:0]                  nq_reg, ss_reg, b_nn_reg, c_nn_reg, dif_reg;
    logic                          c_vneg_reg, d_vneg_reg;
    logic [msd_pkg::VNUM_W-1:0]    vnum_reg;
    logic [msd_pkg::VDEN_W-1:0]    vden_reg;
    msd_pkg::div_stage_t           dout_reg, dout_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            dout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= take;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            dout_reg    <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_zero_reg <= (sample_count == '0);
            nq_ll_reg  <= D'(sample_count[H-1:0]) * D'(square_sum[H-1:0]);
            nq_lh_reg  <= D'(sample_count[H-1:0]) * D'(square_sum[D-1:H]);
            nq_hl_reg  <= D'(sample_count[D-1:H]) * D'(square_sum[H-1:0]);
            nq_hh_reg  <= D'(sample_count[D-1:H]) * D'(square_sum[D-1:H]);
            ss_ll_reg  <= D'(value_sum[H-1:0]) * D'(value_sum[H-1:0]);
            ss_lh_reg  <= D'(value_sum[H-1:0]) * D'(value_sum[D-1:H]);
            ss_hh_reg  <= D'(value_sum[D-1:H]) * D'(value_sum[D-1:H]);
            nn_ll_reg  <= D'(sample_count[H-1:0]) * D'(sample_count[H-1:0]);
            nn_lh_reg  <= D'(sample_count[H-1:0]) * D'(sample_count[D-1:H]);
            nn_hh_reg  <= D'(sample_count[D-1:H]) * D'(sample_count[D-1:H]);
            a_mnum_reg <= (msd_pkg::MNUM_W'(value_sum) << 4)
                        + (msd_pkg::MNUM_W'(value_sum) << 2)
                        + msd_pkg::MNUM_W'(sample_count);
            a_mden_reg <= {sample_count, 1'b0};

            b_zero_reg <= a_zero_reg;
            nq_reg     <= W'(nq_ll_reg) + (W'(nq_lh_reg) << H) + (W'(nq_hl_reg) << H)
                        + (W'(nq_hh_reg) << D);
            ss_reg     <= W'(ss_ll_reg) + (W'(ss_lh_reg) << (H + 1)) + (W'(ss_hh_reg) << D);
            b_nn_reg   <= W'(nn_ll_reg) + (W'(nn_lh_reg) << (H + 1)) + (W'(nn_hh_reg) << D);
            b_mnum_reg <= a_mnum_reg;
            b_mden_reg <= a_mden_reg;
            b_movf_reg <= msd_pkg::MDEN_W'(a_mnum_reg[msd_pkg::MNUM_W-1:D]) >= a_mden_reg;

            c_zero_reg <= b_zero_reg;
            c_vneg_reg <= (nq_reg <= ss_reg);
            dif_reg    <= nq_reg - ss_reg;
            c_nn_reg   <= b_nn_reg;
            c_mnum_reg <= b_mnum_reg;
            c_mden_reg <= b_mden_reg;
            c_movf_reg <= b_movf_reg;

            d_zero_reg <= c_zero_reg;
            d_vneg_reg <= c_vneg_reg;
            vnum_reg   <= (msd_pkg::VNUM_W'(dif_reg) << 7) + (msd_pkg::VNUM_W'(dif_reg) << 6)
                        + (msd_pkg::VNUM_W'(dif_reg) << 3) + msd_pkg::VNUM_W'(c_nn_reg);
            vden_reg   <= {c_nn_reg, 1'b0};
            d_mnum_reg <= c_mnum_reg;
            d_mden_reg <= c_mden_reg;
            d_movf_reg <= c_movf_reg;
        end
    end

    always_comb
    begin
        dout_next.valid = d_valid_reg;
        dout_next.zero  = d_zero_reg;
        dout_next.m_ovf = d_movf_reg;
        dout_next.m_rem = msd_pkg::MDEN_W'(d_mnum_reg[msd_pkg::MNUM_W-1:D]);
        dout_next.m_den = d_mden_reg;
        dout_next.m_lo  = d_mnum_reg[D-1:0];
        dout_next.m_quo = '0;
        dout_next.v_neg = d_vneg_reg;
        dout_next.v_ovf = msd_pkg::VDEN_W'(vnum_reg[msd_pkg::VNUM_W-1:D]) >= vden_reg;
        dout_next.v_rem = msd_pkg::VDEN_W'(vnum_reg[msd_pkg::VNUM_W-1:D]);
        dout_next.v_den = vden_reg;
        dout_next.v_lo  = vnum_reg[D-1:0];
        dout_next.v_quo = '0;
    end

    assign dout = dout_reg;

endmodule

[rtl/msd_div_cell.sv]
// One quotient bit of both restoring dividers (mean and variance).
// Depends on msd_pkg.
module msd_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  msd_pkg::div_stage_t din,
    output msd_pkg::div_stage_t dout
);
    logic [msd_pkg::MDEN_W:0] m_try;
    logic [msd_pkg::VDEN_W:0] v_try;
    logic                     m_fit, v_fit;
    msd_pkg::div_stage_t      stage_reg, stage_next;

    always_comb
    begin
        m_try = {din.m_rem, din.m_lo[msd_pkg::DATA_W-1]};
        v_try = {din.v_rem, din.v_lo[msd_pkg::DATA_W-1]};
        m_fit = m_try >= {1'b0, din.m_den};
        v_fit = v_try >= {1'b0, din.v_den};
        stage_next = din;
        stage_next.m_rem = m_fit ? msd_pkg::MDEN_W'(m_try - {1'b0, din.m_den})
                                 : m_try[msd_pkg::MDEN_W-1:0];
        stage_next.v_rem = v_fit ? msd_pkg::VDEN_W'(v_try - {1'b0, din.v_den})
                                 : v_try[msd_pkg::VDEN_W-1:0];
        stage_next.m_lo  = din.m_lo << 1;
        stage_next.v_lo  = din.v_lo << 1;
        stage_next.m_quo = {din.m_quo[msd_pkg::DATA_W-2:0], m_fit};
        stage_next.v_quo = {din.v_quo[msd_pkg::DATA_W-2:0], v_fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg.valid <= 1'b0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

[rtl/msd_root_cell.sv]
// One step of the bit-by-bit integer square root.
// Depends on msd_pkg.
module msd_root_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  msd_pkg::root_stage_t din,
    output msd_pkg::root_stage_t dout
);
    logic [msd_pkg::DATA_W-1:0] trial;
    logic                       fit;
    msd_pkg::root_stage_t       stage_reg, stage_next;

    always_comb
    begin
        trial = din.res + din.one;
        fit   = din.rad >= trial;
        stage_next     = din;
        stage_next.rad = fit ? din.rad - trial : din.rad;
        stage_next.res = fit ? (din.res >> 1) + din.one : din.res >> 1;
        stage_next.one = din.one >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg.valid <= 1'b0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign dout = stage_reg;

endmodule

[rtl/mean_stddev_from_moments_top.sv]
// Top level: front stages, a row of divider cells, a row of root cells.
// Depends on msd_pkg, msd_in_if, msd_out_if, msd_front, msd_div_cell, msd_root_cell.
//
// channel   dir  fields
// snapshot  in   sample_count, value_sum, square_sum
// result    out  mean_tenths, deviation_tenths
//
// One request per cycle unless the output stalls; 5 front stages, 64 divider
// cells and 32 root cells. Each divider cell resolves one quotient bit, each
// root cell one result bit. The whole row advances together and holds while
// a finished result waits unaccepted. Reset clears the valid bits only.
module mean_stddev_from_moments_top (
    input  logic      clk,
    input  logic      rst_n,
    msd_in_if.sink    snapshot,
    msd_out_if.source result
);
    localparam int unsigned DS = msd_pkg::DIV_STEPS;
    localparam int unsigned RS = msd_pkg::ROOT_STEPS;

    logic                 en;
    msd_pkg::div_stage_t  div_row [0:DS];
    msd_pkg::root_stage_t root_row [0:RS];
    msd_pkg::root_stage_t last;

    assign en = !root_row[RS].valid || result.ready;
    assign snapshot.ready = en;

    msd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .take         (snapshot.valid),
        .sample_count (snapshot.sample_count),
        .value_sum    (snapshot.value_sum),
        .square_sum   (snapshot.square_sum),
        .dout         (div_row[0])
    );

    for (genvar i = 0; i < DS; i++)
    begin : g_div
        msd_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (div_row[i]),
            .dout  (div_row[i+1])
        );
    end

    always_comb
    begin
        root_row[0].valid    = div_row[DS].valid;
        root_row[0].dev_zero = div_row[DS].zero || div_row[DS].v_neg;
        root_row[0].dev_sat  = div_row[DS].v_ovf;
        root_row[0].mean     = div_row[DS].zero  ? '0 :
                               div_row[DS].m_ovf ? '1 : div_row[DS].m_quo;
        root_row[0].rad      = div_row[DS].v_quo;
        root_row[0].res      = '0;
        root_row[0].one      = msd_pkg::DATA_W'(1) << (msd_pkg::DATA_W - 2);
    end

    for (genvar j = 0; j < RS; j++)
    begin : g_root
        msd_root_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (root_row[j]),
            .dout  (root_row[j+1])
        );
    end

    assign last = root_row[RS];
    assign result.valid = last.valid;
    assign result.mean_tenths = last.mean;
    assign result.deviation_tenths = last.dev_zero ? '0 :
                                     last.dev_sat  ? '1 : last.res[msd_pkg::DEV_W-1:0];

endmodule
